[rtl/core/rth_pkg.sv]
// Package for the 8-bit RGB to HSV converter: payload types, widths and constants.
// No dependencies.
package rth_pkg;

  localparam int CH_W      = 8;
  localparam int QUOT_W    = 8;
  localparam int HUE_SPAN  = 179;
  localparam int HUE_DIV_W = 11;
  localparam int HUE_REM_W = 19;
  localparam int SAT_DIV_W = 8;
  localparam int SAT_REM_W = 16;
  localparam int LATENCY   = QUOT_W + 2;

  typedef struct packed {
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] hue_out;
    logic [CH_W-1:0] sat_out;
    logic [CH_W-1:0] val_out;
  } pixel_out_t;

  typedef struct packed {
    logic                 grey;
    logic [CH_W-1:0]      val;
    logic [HUE_REM_W-1:0] hue_rem;
    logic [HUE_DIV_W-1:0] hue_div;
    logic [QUOT_W-1:0]    hue_q;
    logic [SAT_REM_W-1:0] sat_rem;
    logic [SAT_DIV_W-1:0] sat_div;
    logic [QUOT_W-1:0]    sat_q;
  } div_stage_t;

endpackage

[rtl/core/rth_front.sv]
// Front stage: max, min, delta, hue sector and the two dividend/divisor pairs.
// Depends on rth_pkg.
module rth_front import rth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  pixel_in_t  in_px,
  output logic       out_vld,
  output div_stage_t out_stg
);

  logic [CH_W-1:0]      r, g, b, v, mn, delta;
  logic                 rmax, gmax;
  logic signed [11:0]   r12, g12, b12, d12, num, numw;
  logic [10:0]          n_pos;
  div_stage_t           stg_nxt;
  div_stage_t           stg_r;
  logic                 vld_r;

  always_comb begin
    r     = in_px.red_in;
    g     = in_px.green_in;
    b     = in_px.blue_in;
    v     = (r > g) ? r : g;
    v     = (v > b) ? v : b;
    mn    = (r < g) ? r : g;
    mn    = (mn < b) ? mn : b;
    delta = v - mn;
    rmax  = (r == v);
    gmax  = !rmax && (g == v);
    r12   = signed'({4'b0, r});
    g12   = signed'({4'b0, g});
    b12   = signed'({4'b0, b});
    d12   = signed'({4'b0, delta});
    if (rmax) begin
      num = g12 - b12;
    end else if (gmax) begin
      num = (d12 <<< 1) + b12 - r12;
    end else begin
      num = (d12 <<< 2) + r12 - g12;
    end
    numw  = (num < 0) ? num + (d12 <<< 2) + (d12 <<< 1) : num;
    n_pos = numw[10:0];

    stg_nxt.grey    = (delta == '0);
    stg_nxt.val     = v;
    stg_nxt.hue_rem = HUE_REM_W'(n_pos) * HUE_REM_W'(HUE_SPAN)
                    + HUE_REM_W'({delta, 1'b0}) + HUE_REM_W'(delta);
    stg_nxt.hue_div = HUE_DIV_W'({delta, 2'b0}) + HUE_DIV_W'({delta, 1'b0});
    stg_nxt.hue_q   = '0;
    stg_nxt.sat_rem = {delta, 8'b0} - SAT_REM_W'(delta);
    stg_nxt.sat_div = v;
    stg_nxt.sat_q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule

[rtl/core/rth_div_cell.sv]
// One restoring-division cell: resolves quotient bit SHIFT of hue and saturation.
// Depends on rth_pkg.
module rth_div_cell import rth_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  div_stage_t in_stg,
  output logic       out_vld,
  output div_stage_t out_stg
);

  logic [HUE_REM_W-1:0] hue_sh;
  logic [SAT_REM_W-1:0] sat_sh;
  div_stage_t           stg_nxt;
  div_stage_t           stg_r;
  logic                 vld_r;

  always_comb begin
    hue_sh  = HUE_REM_W'(in_stg.hue_div) << SHIFT;
    sat_sh  = SAT_REM_W'(in_stg.sat_div) << SHIFT;
    stg_nxt = in_stg;
    if (in_stg.hue_rem >= hue_sh) begin
      stg_nxt.hue_rem      = in_stg.hue_rem - hue_sh;
      stg_nxt.hue_q[SHIFT] = 1'b1;
    end
    if (in_stg.sat_rem >= sat_sh) begin
      stg_nxt.sat_rem      = in_stg.sat_rem - sat_sh;
      stg_nxt.sat_q[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule

[rtl/core/rgb_to_hsv_8bit_core.sv]
// Top level of the 8-bit RGB to HSV converter: front stage, division cell row, output register.
// Depends on rth_pkg, rth_front, rth_div_cell.
//
//   channel  ports                      accept condition
//   input    start, busy, in_px         start && !busy
//   result   out_valid, out_px          out_valid (one cycle, no stall)
//
// One pixel per clock; busy is always low.
// Pipeline: front stage, eight division cells (one quotient bit each), output register.
// Synchronous active-low reset clears the valid bits of every stage; payload is not reset.
// The receiver cannot stall; every result is shown for exactly one cycle.
module rgb_to_hsv_8bit_core import rth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  pixel_in_t  in_px,
  output logic       out_valid,
  output pixel_out_t out_px
);

  logic       vld [0:QUOT_W];
  div_stage_t stg [0:QUOT_W];
  logic       out_valid_r;
  pixel_out_t out_px_r, out_px_nxt;

  assign busy = 1'b0;

  rth_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_px   (in_px),
    .out_vld (vld[0]),
    .out_stg (stg[0])
  );

  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    rth_div_cell #(.SHIFT(QUOT_W - 1 - i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld[i]),
      .in_stg  (stg[i]),
      .out_vld (vld[i+1]),
      .out_stg (stg[i+1])
    );
  end

  always_comb begin
    out_px_nxt.val_out = stg[QUOT_W].val;
    out_px_nxt.hue_out = stg[QUOT_W].grey ? '0 : stg[QUOT_W].hue_q;
    out_px_nxt.sat_out = stg[QUOT_W].grey ? '0 : stg[QUOT_W].sat_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    out_px_r <= out_px_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_px    = out_px_r;

endmodule

[rtl/core/rth_checker.sv]
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rth_pkg and rgb_to_hsv_8bit_core.
module rth_checker import rth_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input pixel_out_t out_px
);

  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted request produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without request");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_px.hue_out <= 8'(HUE_SPAN)))
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_px.val_out == '0) |-> (out_px.sat_out == '0 && out_px.hue_out == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_px.sat_out == '0) |-> (out_px.hue_out == '0))
    else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_8bit_core rth_checker u_rth_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_px    (out_px)
);
